>>> rtl/core/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants for the AABB frustum cull block
// Input and result words, setting indexes, flag bits.
// ----------------------------------------------------------------------------
package afc_pkg;

  localparam int unsigned NumSettings = 20;
  localparam int unsigned NumCorners  = 8;
  localparam int unsigned WordW       = 32;

  localparam logic [4:0] IdxNear   = 5'd12;
  localparam logic [4:0] IdxFar    = 5'd13;
  localparam logic [4:0] IdxLeft   = 5'd14;
  localparam logic [4:0] IdxRight  = 5'd15;
  localparam logic [4:0] IdxTop    = 5'd16;
  localparam logic [4:0] IdxBottom = 5'd17;
  localparam logic [4:0] IdxTanv   = 5'd18;
  localparam logic [4:0] IdxTanh   = 5'd19;

  localparam logic OpWrite = 1'b0;
  localparam logic OpBox   = 1'b1;

  localparam logic KindAck = 1'b0;
  localparam logic KindBox = 1'b1;

  localparam logic ModeOrtho = 1'b0;
  localparam logic ModePersp = 1'b1;

  localparam logic [5:0] FlagFar   = 6'b000001;
  localparam logic [5:0] FlagNear  = 6'b000010;
  localparam logic [5:0] FlagLeft  = 6'b000100;
  localparam logic [5:0] FlagRight = 6'b001000;
  localparam logic [5:0] FlagUp    = 6'b010000;
  localparam logic [5:0] FlagDown  = 6'b100000;

  typedef struct packed {
    logic               opcode;
    logic [4:0]         setting_index;
    logic signed [31:0] setting_value;
    logic signed [31:0] min_x;
    logic signed [31:0] min_y;
    logic signed [31:0] min_z;
    logic signed [31:0] max_x;
    logic signed [31:0] max_y;
    logic signed [31:0] max_z;
  } in_word_t;

  typedef struct packed {
    logic       result_kind;
    logic       visible;
    logic [5:0] straddle_flags;
  } out_word_t;

  // per-lane verdict
  typedef struct packed {
    logic       in_view;
    logic [5:0] flag;
  } lane_res_t;

  typedef struct packed {
    logic signed [31:0] m0;
    logic signed [31:0] m1;
    logic signed [31:0] m2;
    logic signed [31:0] m3;
  } mrow_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] near_w;
    logic signed [31:0] far_w;
    logic signed [31:0] left_w;
    logic signed [31:0] right_w;
    logic signed [31:0] top_w;
    logic signed [31:0] bottom_w;
  } limits_t;

  typedef struct packed {
    logic signed [31:0] tanv_w;
    logic signed [31:0] tanh_w;
  } tan_t;

endpackage

>>> rtl/core/afc_lane.sv
// ----------------------------------------------------------------------------
// afc_lane: one corner lane
// Transforms one corner by the 3x4 matrix and classifies it. Four stages.
// ----------------------------------------------------------------------------
module afc_lane #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [31:0]    px_i,
  input  logic signed [31:0]    py_i,
  input  logic signed [31:0]    pz_i,
  input  afc_pkg::mrow_t        row0_i,
  input  afc_pkg::mrow_t        row1_i,
  input  afc_pkg::mrow_t        row2_i,
  input  afc_pkg::tan_t         tan_i,
  input  afc_pkg::limits_t      lim_i,
  output afc_pkg::lane_res_t    res_o
);
  import afc_pkg::*;

  localparam int unsigned PW = 64 - FRAC_BITS;

  // stage 1: nine products, floored
  logic signed [PW-1:0] pr_q [9];
  logic signed [31:0]   t_q  [3];
  logic signed [63:0]   pr_full [9];

  always_comb begin
    pr_full[0] = 64'(row0_i.m0) * 64'(px_i);
    pr_full[1] = 64'(row0_i.m1) * 64'(py_i);
    pr_full[2] = 64'(row0_i.m2) * 64'(pz_i);
    pr_full[3] = 64'(row1_i.m0) * 64'(px_i);
    pr_full[4] = 64'(row1_i.m1) * 64'(py_i);
    pr_full[5] = 64'(row1_i.m2) * 64'(pz_i);
    pr_full[6] = 64'(row2_i.m0) * 64'(px_i);
    pr_full[7] = 64'(row2_i.m1) * 64'(py_i);
    pr_full[8] = 64'(row2_i.m2) * 64'(pz_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 9; k++) begin
        pr_q[k] <= pr_full[k][63:FRAC_BITS];
      end
      t_q[0] <= row0_i.m3;
      t_q[1] <= row1_i.m3;
      t_q[2] <= row2_i.m3;
    end
  end

  // stage 2: sums, saturation
  logic signed [PW+1:0] s [3];
  logic signed [31:0]   c_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      s[r] = (PW+2)'(pr_q[3*r]) + (PW+2)'(pr_q[3*r+1]) + (PW+2)'(pr_q[3*r+2])
           + (PW+2)'(t_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int r = 0; r < 3; r++) begin
        if (s[r] > (PW+2)'(signed'(32'h7fffffff))) begin
          c_q[r] <= 32'sh7fffffff;
        end else if (s[r] < (PW+2)'(signed'(32'h80000000))) begin
          c_q[r] <= 32'sh80000000;
        end else begin
          c_q[r] <= s[r][31:0];
        end
      end
    end
  end

  // stage 3: depth and perspective thresholds
  logic signed [32:0]   d;
  logic signed [32:0]   d_q;
  logic signed [31:0]   x_q, y_q;
  logic signed [64:0]   yt_full, xt_full;
  logic signed [64-FRAC_BITS:0] yt_q, xt_q;

  assign d       = -33'(c_q[2]);
  assign yt_full = 65'(tan_i.tanv_w) * 65'(d);
  assign xt_full = 65'(tan_i.tanh_w) * 65'(d);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_q  <= d;
      x_q  <= c_q[0];
      y_q  <= c_q[1];
      yt_q <= yt_full[64:FRAC_BITS];
      xt_q <= xt_full[64:FRAC_BITS];
    end
  end

  // stage 4: classification
  localparam int unsigned TW = 66 - FRAC_BITS;
  logic signed [TW-1:0] xe, ye, yt, xt;
  lane_res_t res_d, res_q;

  always_comb begin
    xe = TW'(x_q);
    ye = TW'(y_q);
    yt = TW'(yt_q);
    xt = TW'(xt_q);
    res_d = '{in_view: 1'b0, flag: 6'd0};
    if (d_q > 33'(lim_i.far_w)) begin
      res_d.flag = FlagFar;
    end else if (d_q < 33'(lim_i.near_w)) begin
      res_d.flag = FlagNear;
    end else if (lim_i.mode == ModeOrtho) begin
      if (x_q > lim_i.right_w) begin
        res_d.flag = FlagRight;
      end else if (x_q < lim_i.left_w) begin
        res_d.flag = FlagLeft;
      end else if (y_q > lim_i.top_w) begin
        res_d.flag = FlagUp;
      end else if (y_q < lim_i.bottom_w) begin
        res_d.flag = FlagDown;
      end else begin
        res_d.in_view = 1'b1;
      end
    end else begin
      if (ye > yt) begin
        res_d.flag = FlagUp;
      end else if (ye < -yt) begin
        res_d.flag = FlagDown;
      end else if (xe > xt) begin
        res_d.flag = FlagRight;
      end else if (xe < -xt) begin
        res_d.flag = FlagLeft;
      end else begin
        res_d.in_view = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) res_q <= res_d;
  end

  assign res_o = res_q;

endmodule

>>> rtl/core/afc_merge.sv
// ----------------------------------------------------------------------------
// afc_merge: combines the eight lane verdicts
// First inside corner wins; else the pairs-minus-singles rule.
// ----------------------------------------------------------------------------
module afc_merge (
  input  afc_pkg::lane_res_t lane_i [8],
  output logic               visible_o,
  output logic [5:0]         flags_o
);
  import afc_pkg::*;

  logic       hit;
  logic [5:0] acc;
  logic [5:0] f;
  logic [1:0] p, sgl;

  always_comb begin
    hit = 1'b0;
    acc = 6'd0;
    for (int i = 0; i < NumCorners; i++) begin
      if (!hit) begin
        if (lane_i[i].in_view) begin
          hit = 1'b1;
        end else begin
          acc = acc | lane_i[i].flag;
        end
      end
    end
    f   = acc;
    p   = 2'(f[0] & f[1]) + 2'(f[2] & f[3]) + 2'(f[4] & f[5]);
    sgl = 2'(f[0] ^ f[1]) + 2'(f[2] ^ f[3]) + 2'(f[4] ^ f[5]);
    visible_o = hit | (p > sgl);
    flags_o   = acc;
  end

endmodule

>>> rtl/core/aabb_frustum_cull_top.sv
// Path from the accepting edge to the result word: input reg, four lane stages,
// merge into the output reg.
// Throughput: one word per cycle unless the output stalls; eight corner lanes in parallel.
// Stall of the output holds the whole pipeline (shared enable).
// Reset: settings all zero, projection_mode orthographic, pipeline empty.
// ----------------------------------------------------------------------------
// aabb_frustum_cull_top: AABB view-frustum culling
// Settings file, eight corner lanes, merge stage, output register.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_top #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  afc_pkg::in_word_t    in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output afc_pkg::out_word_t   out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i
);
  import afc_pkg::*;

  localparam int unsigned Depth = 6;

  logic signed [31:0] set_q [NumSettings];
  logic               mode_q;

  // whole pipeline advances only when the output is not blocked
  logic adv;
  logic [Depth-1:0] vld_q;
  logic [Depth-1:0] kind_q;

  assign adv        = !vld_q[Depth-1] || out_ready_i;
  assign in_ready_o = adv;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSettings; i++) set_q[i] <= '0;
      mode_q <= ModeOrtho;
    end else begin
      if (cfg_valid_i) mode_q <= cfg_data_i;
      if (in_valid_i && adv && in_data_i.opcode == OpWrite &&
          in_data_i.setting_index < 5'(NumSettings)) begin
        set_q[in_data_i.setting_index] <= in_data_i.setting_value;
      end
    end
  end

  in_word_t in_q;
  always_ff @(posedge clk_i) begin
    if (adv) in_q <= in_data_i;
  end

  mrow_t   r0, r1, r2;
  limits_t lim;
  tan_t    tan;
  assign r0 = '{set_q[0], set_q[1], set_q[2], set_q[3]};
  assign r1 = '{set_q[4], set_q[5], set_q[6], set_q[7]};
  assign r2 = '{set_q[8], set_q[9], set_q[10], set_q[11]};
  assign lim = '{mode_q, set_q[IdxNear], set_q[IdxFar], set_q[IdxLeft],
                 set_q[IdxRight], set_q[IdxTop], set_q[IdxBottom]};
  assign tan = '{set_q[IdxTanv], set_q[IdxTanh]};

  // limits travel with the box so later writes do not reach it
  limits_t lim_a_q, lim_b_q, lim_c_q;
  tan_t    tan_a_q, tan_b_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lim_a_q <= lim;
      lim_b_q <= lim_a_q;
      lim_c_q <= lim_b_q;
      tan_a_q <= tan;
      tan_b_q <= tan_a_q;
    end
  end

  lane_res_t lane_res [8];
  for (genvar g = 0; g < 8; g++) begin : g_lane
    afc_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .px_i  (g[2] ? in_q.max_x : in_q.min_x),
      .py_i  (g[1] ? in_q.max_y : in_q.min_y),
      .pz_i  (g[0] ? in_q.max_z : in_q.min_z),
      .row0_i(r0),
      .row1_i(r1),
      .row2_i(r2),
      .tan_i (tan_b_q),
      .lim_i (lim_c_q),
      .res_o (lane_res[g])
    );
  end

  logic       vis;
  logic [5:0] flg;
  afc_merge u_merge (
    .lane_i   (lane_res),
    .visible_o(vis),
    .flags_o  (flg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) kind_q <= {kind_q[Depth-2:0], in_data_i.opcode};
  end

  out_word_t out_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.result_kind    <= kind_q[Depth-2];
      out_q.visible        <= (kind_q[Depth-2] == KindBox) ? vis : 1'b0;
      out_q.straddle_flags <= (kind_q[Depth-2] == KindBox) ? flg : 6'd0;
    end
  end

  assign out_valid_o = vld_q[Depth-1];
  assign out_data_o  = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.result_kind == KindAck |->
    out_data_o.visible == 1'b0 && out_data_o.straddle_flags == 6'd0)
    else $error("ack carries flags");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("stalled while empty");

endmodule

>>> tb/sv/aabb_frustum_cull_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_frustum_cull_checker: result predictor and comparator
// Watches the input, config and result channels. Keeps its own copy of the
// setting words and projection mode, predicts each result word and compares
// it with the oldest prediction.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_checker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  afc_pkg::in_word_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  afc_pkg::out_word_t out_data_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic               cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 box_count_o,
  output int                 visible_count_o
);
  import afc_pkg::*;

  logic signed [31:0] settings_q [NumSettings];
  logic               mode_q;
  out_word_t          expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic signed [63:0] fx_mul(logic signed [63:0] a,
                                                logic signed [63:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p >>> FRAC_BITS;
  endfunction

  function automatic logic signed [63:0] xform(int row, logic signed [63:0] x,
                                               logic signed [63:0] y,
                                               logic signed [63:0] z);
    logic signed [63:0] s;
    int b;
    b = row * 4;
    s = fx_mul(settings_q[b], x) + fx_mul(settings_q[b+1], y)
      + fx_mul(settings_q[b+2], z) + 64'(settings_q[b+3]);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s;
  endfunction

  function automatic out_word_t cull_box(in_word_t w);
    out_word_t r;
    logic [5:0] f;
    logic signed [63:0] px, py, pz, x, y, d, yt, xt;
    int p, q;
    f = '0;
    r = '0;
    r.result_kind = KindBox;
    for (int i = 0; i < NumCorners; i++) begin
      px = i[2] ? 64'(w.max_x) : 64'(w.min_x);
      py = i[1] ? 64'(w.max_y) : 64'(w.min_y);
      pz = i[0] ? 64'(w.max_z) : 64'(w.min_z);
      x = xform(0, px, py, pz);
      y = xform(1, px, py, pz);
      d = -xform(2, px, py, pz);
      if (d > settings_q[IdxFar]) begin f |= FlagFar; continue; end
      if (d < settings_q[IdxNear]) begin f |= FlagNear; continue; end
      if (mode_q == ModeOrtho) begin
        if (x > settings_q[IdxRight]) begin f |= FlagRight; continue; end
        if (x < settings_q[IdxLeft]) begin f |= FlagLeft; continue; end
        if (y > settings_q[IdxTop]) begin f |= FlagUp; continue; end
        if (y < settings_q[IdxBottom]) begin f |= FlagDown; continue; end
      end else begin
        yt = fx_mul(settings_q[IdxTanv], d);
        xt = fx_mul(settings_q[IdxTanh], d);
        if (y > yt) begin f |= FlagUp; continue; end
        if (y < -yt) begin f |= FlagDown; continue; end
        if (x > xt) begin f |= FlagRight; continue; end
        if (x < -xt) begin f |= FlagLeft; continue; end
      end
      r.visible = 1'b1;
      r.straddle_flags = f;
      return r;
    end
    p = int'(f[0] & f[1]) + int'(f[2] & f[3]) + int'(f[4] & f[5]);
    q = int'(f[0] ^ f[1]) + int'(f[2] ^ f[3]) + int'(f[4] ^ f[5]);
    r.visible = (p - q >= 1);
    r.straddle_flags = f;
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    out_word_t e, a;
    if (!rst_ni) begin
      for (int i = 0; i < NumSettings; i++) settings_q[i] <= '0;
      mode_q <= ModeOrtho;
      expected_q.delete();
      fail_count_o <= 0;
      box_count_o <= 0;
      visible_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) mode_q <= cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.opcode == OpWrite) begin
          if (in_data_i.setting_index < NumSettings)
            settings_q[in_data_i.setting_index] <= in_data_i.setting_value;
          expected_q.push_back('0);
        end else begin
          e = cull_box(in_data_i);
          expected_q.push_back(e);
          box_count_o <= box_count_o + 1;
          if (e.visible) visible_count_o <= visible_count_o + 1;
        end
      end
      if (out_valid_i && out_ready_i) begin
        a = out_data_i;
        if (expected_q.size() == 0) begin
          $error("unexpected result word %h", a);
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (a.result_kind !== e.result_kind) begin
            $error("result_kind: expected %0d actual %0d", e.result_kind, a.result_kind);
            fail_count_o <= fail_count_o + 1;
          end else if (a.visible !== e.visible) begin
            $error("visible: expected %0d actual %0d", e.visible, a.visible);
            fail_count_o <= fail_count_o + 1;
          end else if (a.straddle_flags !== e.straddle_flags) begin
            $error("straddle_flags: expected %h actual %h",
                   e.straddle_flags, a.straddle_flags);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/sv/aabb_frustum_cull_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_frustum_cull_top_test: testbench top for the frustum cull block
// Drives setting writes, directed and random boxes in both projection
// modes with random gaps and stalls; the checker does the comparing.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_top_test;
  import afc_pkg::*;

  localparam int Latency = 6;
  localparam int WatchdogLimit = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i = 1'b0;
  int        fail_count, pending, box_count, visible_count;
  int        idle_cycles = 0;
  bit        hold_off = 1'b0;
  bit        stim_done = 1'b0;

  always #10 clk_i = ~clk_i;

  aabb_frustum_cull_top u_top (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  aabb_frustum_cull_checker u_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending),
    .box_count_o(box_count), .visible_count_o(visible_count)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 2) == 0) return 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 3);
  endfunction

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  // receiver: random stalls, one long hold-off on request
  always @(posedge clk_i) begin
    int n;
    if (rst_ni) begin
      if (hold_off) begin
        out_ready_i <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
        out_ready_i <= 1'b1;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_ready_i <= 1'b0;
          repeat (n) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("watchdog expired, pending %0d", pending);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(in_word_t w, bit gaps);
    int n;
    n = gaps ? gap_len() : 0;
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic put_setting(logic [4:0] idx, logic signed [31:0] v, bit gaps);
    in_word_t w;
    w = '0;
    w.opcode = OpWrite;
    w.setting_index = idx;
    w.setting_value = v;
    send(w, gaps);
  endtask

  task automatic put_box(logic signed [31:0] x0, y0, z0, x1, y1, z1, bit gaps);
    in_word_t w;
    w = '0;
    w.opcode = OpBox;
    w.min_x = x0; w.min_y = y0; w.min_z = z0;
    w.max_x = x1; w.max_y = y1; w.max_z = z1;
    w.setting_index = 5'($urandom());
    w.setting_value = $urandom();
    send(w, gaps);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic set_mode(logic m);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= m;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_view(bit gaps);
    logic signed [31:0] s;
    for (int i = 0; i < 12; i++) begin
      s = (i % 5 == 0) ? 32'sh10000 : 32'sh0;
      if ($urandom_range(0, 3) == 0) s = s + $signed($urandom_range(0, 'h8000)) - 'sh4000;
      if (i % 4 == 3) s = $signed($urandom_range(0, 4 << 16)) - (2 << 16);
      put_setting(i[4:0], s, gaps);
    end
    put_setting(IdxNear, $urandom_range(0, 2 << 16), gaps);
    put_setting(IdxFar, $urandom_range(8 << 16, 30 << 16), gaps);
    put_setting(IdxLeft, -$signed($urandom_range(1 << 16, 10 << 16)), gaps);
    put_setting(IdxRight, $urandom_range(1 << 16, 10 << 16), gaps);
    put_setting(IdxTop, $urandom_range(1 << 16, 10 << 16), gaps);
    put_setting(IdxBottom, -$signed($urandom_range(1 << 16, 10 << 16)), gaps);
    put_setting(IdxTanv, $urandom_range('h4000, 2 << 16), gaps);
    put_setting(IdxTanh, $urandom_range('h4000, 2 << 16), gaps);
  endtask

  task automatic random_item();
    logic signed [31:0] a, b;
    logic [255:0] raw;
    in_word_t w;
    case ($urandom_range(0, 19))
      0: put_setting(5'($urandom_range(0, 31)), $urandom(), 1'b1);
      1: begin
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
               $urandom(), $urandom(), $urandom()};
        w = raw[$bits(in_word_t)-1:0];
        w.opcode = OpBox;
        send(w, 1'b1);
      end
      default: begin
        a = rand_coord(); b = rand_coord();
        put_box(rand_coord(), rand_coord(), a, rand_coord(), rand_coord(), b, 1'b1);
      end
    endcase
  endtask

  initial begin
    out_ready_i = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero settings, then directed extremes
    put_box('0, '0, '0, '0, '0, '0, 1'b0);
    put_setting(5'd20, 32'sh7fffffff, 1'b0);
    put_setting(5'd31, 32'sh80000000, 1'b0);
    load_view(1'b0);
    put_box(-32'sh10000, -32'sh10000, -32'sh50000, 32'sh10000, 32'sh10000, -32'sh30000, 1'b0);
    put_box(-32'sh640000, -32'sh10000, -32'sh50000, 32'sh640000, 32'sh10000, -32'sh50000, 1'b0);
    put_box(32'sh80000000, 32'sh80000000, 32'sh80000000,
            32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0);
    put_box(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
            32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0);
    put_box('0, '0, 32'sh7fffffff, '0, '0, 32'sh7fffffff, 1'b0);
    put_box('0, 32'sh640000, -32'sh50000, '0, 32'sh640000, -32'sh50000, 1'b0);
    put_box('0, -32'sh640000, -32'sh50000, '0, -32'sh640000, -32'sh50000, 1'b0);
    set_mode(ModePersp);
    put_box(-32'sh10000, -32'sh10000, -32'sh50000, 32'sh10000, 32'sh10000, -32'sh30000, 1'b0);
    put_box(32'sh640000, '0, -32'sh50000, 32'sh640000, '0, -32'sh50000, 1'b0);
    put_box(-32'sh640000, '0, -32'sh50000, -32'sh640000, '0, -32'sh50000, 1'b0);
    put_box(-32'sh640000, -32'sh640000, -32'sh50000, 32'sh640000, 32'sh640000, -32'sh50000, 1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      set_mode(phase[0] ? ModeOrtho : ModePersp);
      load_view(1'b1);
      if (phase == 1) begin
        hold_off = 1'b1;
        for (int i = 0; i < 40; i++) random_item();
      end
      for (int i = 0; i < 250; i++) random_item();
      if (phase == 3) drain();
    end

    drain();
    stim_done = 1'b1;
    $display("covered %0d box tests (%0d visible) in both projection modes",
             box_count, visible_count);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

>>> filelist.f
rtl/core/afc_pkg.sv
rtl/core/afc_lane.sv
rtl/core/afc_merge.sv
rtl/core/aabb_frustum_cull_top.sv
tb/sv/aabb_frustum_cull_checker.sv
tb/sv/aabb_frustum_cull_top_test.sv
